[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MTES_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MTES_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtes_pkg.sv]
// types, constants and helper functions of the midi track event serializer
// no dependencies
`timescale 1ns / 1ps

package mtes_pkg;

  // sizes of one job (the bytes that one input item causes)
  localparam int JobBytes = 10;
  localparam int CntW     = 4;

  // byte constants of the track body
  localparam logic [7:0] VlqMask    = 8'h7F;
  localparam logic [7:0] VlqCont    = 8'h80;
  localparam logic [7:0] StatusSys  = 8'hF0;
  localparam logic [7:0] StatusMeta = 8'hFF;
  localparam logic [7:0] MetaEot    = 8'h2F;
  localparam logic [7:0] EotLen     = 8'h00;

  typedef enum logic [1:0] {
    MODE_EVENT   = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_END     = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [27:0] event_time;
    logic [7:0]  status;
    logic [7:0]  data_first;
    logic [6:0]  data_second;
    logic [27:0] sysex_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] track_length;
  } out_item_t;

  // bytes to emit, their count, and whether the byte count clears after them
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     clr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // number of 7-bit groups of a variable-length quantity
  function automatic logic [2:0] vlq_groups(logic [27:0] v);
    logic [2:0] n;
    if (v[27:21] != '0) begin
      n = 3'd4;
    end else if (v[20:14] != '0) begin
      n = 3'd3;
    end else if (v[13:7] != '0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  // one byte of a variable-length quantity, group g counted from the lsb
  function automatic logic [7:0] vlq_byte(logic [27:0] v, logic [1:0] g);
    logic [6:0] grp;
    case (g)
      2'd0:    grp = v[6:0];
      2'd1:    grp = v[13:7];
      2'd2:    grp = v[20:14];
      default: grp = v[27:21];
    endcase
    return ((g != 2'd0) ? VlqCont : 8'h00) | ({1'b0, grp} & VlqMask);
  endfunction

endpackage

[rtl/mtes_front.sv]
// front end: accepts items, tracks time and running status, builds byte jobs
// depends on mtes_pkg
`timescale 1ns / 1ps

module mtes_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mtes_pkg::in_item_t  in_item_i,
  input  mtes_pkg::fifo_stat_t fifo_stat_i,
  output logic                fifo_push_o,
  output mtes_pkg::job_t      fifo_wdata_o
);

  localparam int CntW_L = mtes_pkg::CntW;

  logic [27:0] prev_q, prev_d;
  logic [27:0] eot_q, eot_d;
  logic [7:0]  rs_q, rs_d;
  logic        accept;
  mtes_pkg::job_t job;

  assign full   = fifo_stat_i.full;
  assign accept = push && !fifo_stat_i.full;

  // classify the item and lay out its bytes in order
  always_comb begin
    logic [CntW_L-1:0] idx;
    logic [27:0]       delta;
    logic [27:0]       len;
    logic [2:0]        ngrp;
    logic [2:0]        lgrp;
    logic [3:0]        nib;
    idx   = '0;
    job   = '0;
    ngrp  = '0;
    lgrp  = '0;
    prev_d = prev_q;
    eot_d  = eot_q;
    rs_d   = rs_q;
    delta  = in_item_i.event_time - prev_q;
    len    = in_item_i.sysex_length;
    nib    = in_item_i.status[7:4];
    case (in_item_i.mode)
      mtes_pkg::MODE_EVENT: begin
        if (in_item_i.status == mtes_pkg::StatusMeta &&
            in_item_i.data_first == mtes_pkg::MetaEot) begin
          // end-of-track meta only records its time
          eot_d = in_item_i.event_time;
        end else begin
          ngrp = mtes_pkg::vlq_groups(delta);
          for (int g = 3; g >= 0; g--) begin
            if (3'(g) < ngrp) begin
              job.bytes[idx] = mtes_pkg::vlq_byte(delta, 2'(g));
              idx = idx + CntW_L'(1);
            end
          end
          prev_d = in_item_i.event_time;
          if (in_item_i.status != rs_q || in_item_i.status >= mtes_pkg::StatusSys) begin
            job.bytes[idx] = in_item_i.status;
            idx = idx + CntW_L'(1);
          end
          rs_d = in_item_i.status;
          case (nib) inside
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
              job.bytes[idx] = in_item_i.data_first;
              idx = idx + CntW_L'(1);
              job.bytes[idx] = {1'b0, in_item_i.data_second};
              idx = idx + CntW_L'(1);
            end
            4'hC, 4'hD: begin
              job.bytes[idx] = in_item_i.data_first;
              idx = idx + CntW_L'(1);
            end
            4'hF: begin
              if (in_item_i.status == mtes_pkg::StatusMeta) begin
                job.bytes[idx] = in_item_i.data_first;
                idx = idx + CntW_L'(1);
              end
              lgrp = mtes_pkg::vlq_groups(len);
              for (int g = 3; g >= 0; g--) begin
                if (3'(g) < lgrp) begin
                  job.bytes[idx] = mtes_pkg::vlq_byte(len, 2'(g));
                  idx = idx + CntW_L'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      mtes_pkg::MODE_PAYLOAD: begin
        job.bytes[idx] = in_item_i.payload_byte;
        idx = idx + CntW_L'(1);
      end
      mtes_pkg::MODE_END: begin
        // delta to the recorded end time, then the end marker
        delta = (eot_q > prev_q) ? (eot_q - prev_q) : '0;
        ngrp  = mtes_pkg::vlq_groups(delta);
        for (int g = 3; g >= 0; g--) begin
          if (3'(g) < ngrp) begin
            job.bytes[idx] = mtes_pkg::vlq_byte(delta, 2'(g));
            idx = idx + CntW_L'(1);
          end
        end
        job.bytes[idx] = mtes_pkg::StatusMeta;
        idx = idx + CntW_L'(1);
        job.bytes[idx] = mtes_pkg::MetaEot;
        idx = idx + CntW_L'(1);
        job.bytes[idx] = mtes_pkg::EotLen;
        idx = idx + CntW_L'(1);
        job.clr = 1'b1;
        prev_d  = '0;
        eot_d   = '0;
        rs_d    = '0;
      end
      default: begin
      end
    endcase
    job.cnt = idx;
  end

  assign fifo_push_o  = accept && (job.cnt != '0);
  assign fifo_wdata_o = job;

  // track state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      eot_q  <= '0;
      rs_q   <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
      eot_q  <= eot_d;
      rs_q   <= rs_d;
    end
  end

endmodule

[rtl/mtes_fifo.sv]
// two-entry job queue between the front end and the byte sequencer
// depends on mtes_pkg
`timescale 1ns / 1ps

module mtes_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mtes_pkg::job_t       wdata_i,
  input  logic                 pop_i,
  output mtes_pkg::job_t       rdata_o,
  output mtes_pkg::fifo_stat_t stat_o
);

  mtes_pkg::job_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign rdata_o      = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/mtes_back.sv]
// back end: walks each job one byte per cycle into the output register,
// whenever that register is free or being popped; depends on mtes_pkg
`timescale 1ns / 1ps

module mtes_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtes_pkg::fifo_stat_t fifo_stat_i,
  input  mtes_pkg::job_t       fifo_rdata_i,
  output logic                 fifo_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output mtes_pkg::out_item_t  out_item_o
);

  mtes_pkg::job_t      job_q;
  logic                job_vld_q;
  logic [mtes_pkg::CntW-1:0] idx_q, idx_d;
  logic [31:0]         count_q, count_d;
  mtes_pkg::out_item_t out_q, out_d;
  logic                out_vld_q, out_vld_d;
  logic                advance;
  logic                is_last;
  logic                load;

  // next byte moves out whenever the output register is free or being taken
  always_comb begin
    advance   = job_vld_q && (!out_vld_q || pop);
    is_last   = (idx_q == (job_q.cnt - mtes_pkg::CntW'(1)));
    load      = !fifo_stat_i.empty && (!job_vld_q || (advance && is_last));
    out_d     = out_q;
    out_vld_d = out_vld_q;
    idx_d     = idx_q;
    count_d   = count_q;
    if (advance) begin
      out_d.out_byte     = job_q.bytes[idx_q];
      out_d.last         = is_last;
      out_d.track_length = count_q + 32'd1;
      out_vld_d          = 1'b1;
      count_d            = (is_last && job_q.clr) ? 32'd0 : (count_q + 32'd1);
      idx_d              = idx_q + mtes_pkg::CntW'(1);
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      idx_d = '0;
    end
  end

  assign fifo_pop_o = load;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  // sequencer control and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        job_vld_q <= 1'b1;
      end else if (advance && is_last) begin
        job_vld_q <= 1'b0;
      end
      idx_q     <= idx_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // job and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= fifo_rdata_i;
    end
    out_q <= out_d;
  end

endmodule

[rtl/midi_track_event_serializer.sv]
// top level of the midi track event serializer
// depends on mtes_pkg, mtes_front, mtes_fifo, mtes_back and assert_macros.svh
`timescale 1ns / 1ps

// Turns time-sorted MIDI events into MTrk body bytes: delta times as
// variable-length quantities, running status, data bytes, sysex/meta headers,
// payload bytes, and the end marker on an end item, which also restarts the
// track. Each result word is one byte, tagged last on the final byte of its
// item, with the running body length. An item causes up to 10 bytes, emitted
// one per cycle while the output register is free or being popped; an item
// with no byte never enters the queue. The first byte of an item passes the
// queue entry, the job register and the output register to the result ports.
// The front end feeds a two-entry job queue and the sequencer holds one more
// job, so the input runs up to three jobs ahead of the byte being emitted and
// raises full once the queue holds two jobs.

`include "assert_macros.svh"

module midi_track_event_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mtes_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output mtes_pkg::out_item_t out_item_o
);

  logic                 fifo_push;
  logic                 fifo_pop;
  mtes_pkg::job_t       fifo_wdata;
  mtes_pkg::job_t       fifo_rdata;
  mtes_pkg::fifo_stat_t fifo_stat;

  // item classification and job building
  mtes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .fifo_stat_i  (fifo_stat),
    .fifo_push_o  (fifo_push),
    .fifo_wdata_o (fifo_wdata)
  );

  // job queue
  mtes_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .stat_o  (fifo_stat)
  );

  // byte sequencer and output register
  mtes_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_stat_i  (fifo_stat),
    .fifo_rdata_i (fifo_rdata),
    .fifo_pop_o   (fifo_pop),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

  // queue integrity checks
  `MTES_ASSERT(a_no_push_when_full, !(fifo_push && fifo_stat.full), "job queue overflow")
  `MTES_ASSERT_IMPLY(a_pop_needs_entry, fifo_pop, !fifo_stat.empty, "job queue underflow")
  `MTES_ASSERT_NEXT(a_push_fills, fifo_push, !fifo_stat.empty, "pushed job went missing")

endmodule
